[hw/rtl/pib_pkg.sv]
package pib_pkg;

  localparam int unsigned PixelColorWidth = 32;
  localparam int unsigned IndexWidth      = 8;
  localparam int unsigned CountWidth      = 9;

  typedef struct packed {
    logic [PixelColorWidth-1:0] pixel_color;
    logic                       start_of_image;
  } pixel_t;

  typedef struct packed {
    logic [IndexWidth-1:0] palette_index;
    logic                  is_new;
    logic                  overflow;
    logic [CountWidth-1:0] color_count;
  } result_t;

  // Control bits of one lookup word walking down the cell chain
  typedef struct packed {
    logic valid;
    logic active;
    logic found;
    logic fresh;
  } probe_ctrl_t;

endpackage

[hw/rtl/pib_cell.sv]
module pib_cell #(
  parameter int unsigned PALETTE_DEPTH = 256,
  parameter int unsigned COLOR_WIDTH   = 32,
  parameter int unsigned CELL_IDX      = 0,
  localparam int unsigned IdxW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1,
  localparam int unsigned CntW = $clog2(PALETTE_DEPTH + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  advance_i,
  input  logic [CntW-1:0]       count_i,
  input  pib_pkg::probe_ctrl_t  ctrl_i,
  input  logic [COLOR_WIDTH-1:0] color_i,
  input  logic [IdxW-1:0]       idx_i,
  output pib_pkg::probe_ctrl_t  ctrl_o,
  output logic [COLOR_WIDTH-1:0] color_o,
  output logic [IdxW-1:0]       idx_o
);

  localparam logic [CntW-1:0] CellPos = CntW'(CELL_IDX);
  localparam logic [IdxW-1:0] CellIdx = IdxW'(CELL_IDX);

  logic [COLOR_WIDTH-1:0] store_q;
  pib_pkg::probe_ctrl_t   ctrl_q, ctrl_d;
  logic [COLOR_WIDTH-1:0] color_q;
  logic [IdxW-1:0]        idx_q;
  logic                   searching;
  logic                   hit;
  logic                   take;

  assign searching = ctrl_i.valid && ctrl_i.active && !ctrl_i.found;
  // only entries below the fill count hold colors of this image
  assign hit  = searching && (CellPos < count_i) && (store_q == color_i);
  // first free entry: append the color here
  assign take = searching && (CellPos == count_i);

  always_comb begin
    ctrl_d = ctrl_i;
    if (hit || take) begin
      ctrl_d.found = 1'b1;
    end
    if (take) begin
      ctrl_d.fresh = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '0;
    end else if (advance_i) begin
      ctrl_q <= ctrl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      color_q <= color_i;
      idx_q   <= (hit || take) ? CellIdx : idx_i;
      if (take) begin
        store_q <= color_i;
      end
    end
  end

  assign ctrl_o  = ctrl_q;
  assign color_o = color_q;
  assign idx_o   = idx_q;

endmodule

[hw/rtl/palette_index_builder.sv]
// Palette index builder: maps each pixel color to its index in a palette of
// distinct colors, appending unseen colors at the next free index while one is left.
// Input channel in_*: one pixel word (color, start_of_image). A word is taken
// when in_valid_i is high and in_stall_o is low. Output channel out_*: one
// result word (palette_index, is_new, overflow, color_count) per pixel.
// Each pixel walks a chain of PALETTE_DEPTH cells, one cell per cycle while
// the chain advances; each cell holds one palette entry and compares it
// against the passing color. An accepted pixel goes through the entry
// register, the cell registers in order and then the output register, and
// only one pixel is in the chain at a time, so no new pixel is taken until
// the previous one leaves the chain. A new pixel may be taken while the
// previous result still waits in the output register.
// Reset empties the palette and clears the overflow flag; entry contents are
// not cleared. A start_of_image word empties the palette before its own
// lookup. While out_stall_i holds a waiting result, a finished lookup freezes
// the whole chain until the output register frees up.
module palette_index_builder #(
  parameter int unsigned PALETTE_DEPTH = 256,
  parameter int unsigned COLOR_WIDTH   = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  pib_pkg::pixel_t  in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output pib_pkg::result_t out_data_o
);

  localparam int unsigned IdxW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(PALETTE_DEPTH + 1);

  pib_pkg::probe_ctrl_t   ctrl_w  [PALETTE_DEPTH+1];
  logic [COLOR_WIDTH-1:0] color_w [PALETTE_DEPTH+1];
  logic [IdxW-1:0]        idx_w   [PALETTE_DEPTH+1];

  logic                   busy_q, busy_d;
  logic [CntW-1:0]        count_q, count_d;
  logic                   ovf_q, ovf_d;
  pib_pkg::probe_ctrl_t   ent_ctrl_q, ent_ctrl_d;
  logic [COLOR_WIDTH-1:0] ent_color_q;
  logic                   out_valid_q, out_valid_d;
  pib_pkg::result_t       out_q;

  logic                   accept;
  logic                   advance;
  logic                   exit_take;
  pib_pkg::probe_ctrl_t   exit_ctrl;
  logic                   new_ovf;
  logic [CntW-1:0]        new_count;

  assign in_stall_o = busy_q;
  assign accept     = in_valid_i && !busy_q;
  assign exit_ctrl  = ctrl_w[PALETTE_DEPTH];
  // hold the chain while a finished word cannot move into the output register
  assign advance    = !(exit_ctrl.valid && out_valid_q && out_stall_i);
  assign exit_take  = exit_ctrl.valid && advance;

  assign new_ovf   = ovf_q || (exit_ctrl.active && !exit_ctrl.found);
  assign new_count = exit_ctrl.fresh ? (count_q + CntW'(1)) : count_q;

  always_comb begin
    busy_d      = busy_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    out_valid_d = out_valid_q;
    ent_ctrl_d  = '0;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (accept) begin
      busy_d           = 1'b1;
      ent_ctrl_d.valid = 1'b1;
      if (in_data_i.start_of_image) begin
        count_d           = '0;
        ovf_d             = 1'b0;
        ent_ctrl_d.active = 1'b1;
      end else begin
        ent_ctrl_d.active = !ovf_q;
      end
    end
    if (exit_take) begin
      busy_d      = 1'b0;
      count_d     = new_count;
      ovf_d       = new_ovf;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
      ent_ctrl_q  <= '0;
    end else begin
      busy_q      <= busy_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
      if (advance) begin
        ent_ctrl_q <= ent_ctrl_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ent_color_q <= in_data_i.pixel_color[COLOR_WIDTH-1:0];
    end
    if (exit_take) begin
      out_q.palette_index <= exit_ctrl.found
                             ? pib_pkg::IndexWidth'(idx_w[PALETTE_DEPTH]) : '0;
      out_q.is_new        <= exit_ctrl.fresh;
      out_q.overflow      <= new_ovf;
      out_q.color_count   <= pib_pkg::CountWidth'(new_count);
    end
  end

  assign ctrl_w[0]  = ent_ctrl_q;
  assign color_w[0] = ent_color_q;
  assign idx_w[0]   = '0;

  for (genvar i = 0; i < PALETTE_DEPTH; i++) begin : g_cell
    pib_cell #(
      .PALETTE_DEPTH(PALETTE_DEPTH),
      .COLOR_WIDTH  (COLOR_WIDTH),
      .CELL_IDX     (i)
    ) u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .advance_i(advance),
      .count_i  (count_q),
      .ctrl_i   (ctrl_w[i]),
      .color_i  (color_w[i]),
      .idx_i    (idx_w[i]),
      .ctrl_o   (ctrl_w[i+1]),
      .color_o  (color_w[i+1]),
      .idx_o    (idx_w[i+1])
    );
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
